// ===== rtl/rsq_pkg.sv =====
// ============================================================================
// Relay switch sequencer package
// Command codes, field widths and the item and result records that the
// sequencer modules share.
// ============================================================================
package rsq_pkg;

   // Widths of the item and result fields.
   localparam int unsigned CMD_WIDTH  = 3;
   localparam int unsigned MASK_WIDTH = 16;

   // Reset value of the exclusive group mask: relay 0 is exclusive.
   localparam logic [MASK_WIDTH-1:0] EXCLUSIVE_MASK_RESET = 16'h0001;

   // Command codes carried by an input item.
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TURN_ON   = 3'd0,
      CMD_TURN_OFF  = 3'd1,
      CMD_OFF_ALL   = 3'd2,
      CMD_QUERY     = 3'd3,
      CMD_EXCL_TICK = 3'd4,
      CMD_CONC_TICK = 3'd5
   } cmd_type;

   // One input item as it sits in the input register.
   typedef struct packed {
      logic [CMD_WIDTH-1:0]  command;
      logic [MASK_WIDTH-1:0] relay_mask;
   } item_type;

   // One result item as the core hands it to the result register.
   typedef struct packed {
      logic [MASK_WIDTH-1:0] switched_off;
      logic [MASK_WIDTH-1:0] switched_on;
      logic                  all_requested_on;
      logic [MASK_WIDTH-1:0] actual_status;
   } result_type;

endpackage

// ===== rtl/rsq_req_if.sv =====
// ============================================================================
// Relay sequencer request channel
// Valid/ready channel that carries one command item into the sequencer.
// ============================================================================
interface rsq_req_if;

   logic                             valid;
   logic                             ready;
   logic [rsq_pkg::CMD_WIDTH-1:0]    command;
   logic [rsq_pkg::MASK_WIDTH-1:0]   relay_mask;

   modport source (output valid, output command, output relay_mask, input ready);
   modport sink   (input valid, input command, input relay_mask, output ready);

endinterface

// ===== rtl/rsq_rsp_if.sv =====
// ============================================================================
// Relay sequencer response channel
// Valid/ready channel that carries one result item out of the sequencer.
// ============================================================================
interface rsq_rsp_if;

   logic                             valid;
   logic                             ready;
   logic [rsq_pkg::MASK_WIDTH-1:0]   switched_off;
   logic [rsq_pkg::MASK_WIDTH-1:0]   switched_on;
   logic                             all_requested_on;
   logic [rsq_pkg::MASK_WIDTH-1:0]   actual_status;

   modport source (output valid, output switched_off, output switched_on,
                   output all_requested_on, output actual_status, input ready);
   modport sink   (input valid, input switched_off, input switched_on,
                   input all_requested_on, input actual_status, output ready);

endinterface

// ===== rtl/rsq_tick.sv =====
// ============================================================================
// Relay group tick
// Combinational control step for one relay group: switches off relays that
// are on but no longer requested, then switches on requested relays that are
// off, either all at once or only the lowest-indexed one.
// ============================================================================
module rsq_tick #(
   parameter int unsigned WIDTH  = 16,
   parameter bit          SINGLE = 1'b0
) (
   input  logic [WIDTH-1:0] request,
   input  logic [WIDTH-1:0] actual,
   output logic [WIDTH-1:0] actual_next,
   output logic [WIDTH-1:0] going_off,
   output logic [WIDTH-1:0] going_on
);

   logic [WIDTH-1:0] kept;
   logic [WIDTH-1:0] pending;

   // Relays that stay on are those both on and requested.
   assign going_off = actual & ~request;
   assign kept      = actual & request;
   assign pending   = request & ~kept;

   // The exclusive group picks only the lowest pending relay.
   generate
      if (SINGLE) begin : g_single
         assign going_on = pending & (~pending + WIDTH'(1));
      end else begin : g_all
         assign going_on = pending;
      end
   endgenerate

   assign actual_next = kept | going_on;

endmodule

// ===== rtl/rsq_core.sv =====
// ============================================================================
// Relay sequencer core
// Holds the exclusive group mask and the requested and actual relay masks,
// decodes one command item and produces its result in a single pass.
// ============================================================================
module rsq_core #(
   parameter int unsigned RELAY_COUNT = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  rsq_pkg::item_type              item,
   input  logic                           csr_wr_en,
   input  logic [rsq_pkg::MASK_WIDTH-1:0] csr_wr_data,
   output rsq_pkg::result_type            result
);

   localparam int unsigned FW = rsq_pkg::MASK_WIDTH;

   logic [FW-1:0]          excl_mask_ff;
   logic [RELAY_COUNT-1:0] excl_req_ff, excl_req_in;
   logic [RELAY_COUNT-1:0] conc_req_ff, conc_req_in;
   logic [RELAY_COUNT-1:0] excl_act_ff, excl_act_in;
   logic [RELAY_COUNT-1:0] conc_act_ff, conc_act_in;

   logic [RELAY_COUNT-1:0] mask_w;
   logic [RELAY_COUNT-1:0] excl_w;
   logic [RELAY_COUNT-1:0] excl_part;
   logic [RELAY_COUNT-1:0] conc_part;
   logic                   hits_excl;

   logic [RELAY_COUNT-1:0] excl_tick_act, excl_tick_off, excl_tick_on;
   logic [RELAY_COUNT-1:0] conc_tick_act, conc_tick_off, conc_tick_on;

   logic [RELAY_COUNT-1:0] off_w, on_w, status_w;
   logic                   answer;

   // Fit the 16-bit fields to the relay count; bits beyond it are ignored.
   generate
      for (genvar i = 0; i < RELAY_COUNT; i++) begin : g_fit_in
         if (i < FW) begin : g_live
            assign mask_w[i] = item.relay_mask[i];
            assign excl_w[i] = excl_mask_ff[i];
         end else begin : g_dead
            assign mask_w[i] = 1'b0;
            assign excl_w[i] = 1'b0;
         end
      end
   endgenerate

   assign excl_part = mask_w & excl_w;
   assign conc_part = mask_w & ~excl_w;
   assign hits_excl = |excl_part;

   // One tick unit per group.
   rsq_tick #(.WIDTH(RELAY_COUNT), .SINGLE(1'b1)) u_excl_tick (
      .request     (excl_req_ff),
      .actual      (excl_act_ff),
      .actual_next (excl_tick_act),
      .going_off   (excl_tick_off),
      .going_on    (excl_tick_on)
   );

   rsq_tick #(.WIDTH(RELAY_COUNT), .SINGLE(1'b0)) u_conc_tick (
      .request     (conc_req_ff),
      .actual      (conc_act_ff),
      .actual_next (conc_tick_act),
      .going_off   (conc_tick_off),
      .going_on    (conc_tick_on)
   );

   // Command decode: next request and actual masks and the result fields.
   always_comb begin
      excl_req_in = excl_req_ff;
      conc_req_in = conc_req_ff;
      excl_act_in = excl_act_ff;
      conc_act_in = conc_act_ff;
      off_w       = '0;
      on_w        = '0;
      answer      = 1'b0;
      unique case (item.command)
         rsq_pkg::CMD_TURN_ON: begin
            if (hits_excl) excl_req_in = excl_req_ff | excl_part;
            else           conc_req_in = conc_req_ff | conc_part;
         end
         rsq_pkg::CMD_TURN_OFF: begin
            if (hits_excl) excl_req_in = excl_req_ff & ~excl_part;
            else           conc_req_in = conc_req_ff & ~conc_part;
         end
         rsq_pkg::CMD_OFF_ALL: begin
            excl_req_in = '0;
            conc_req_in = '0;
         end
         rsq_pkg::CMD_QUERY: begin
            answer = (((excl_req_ff | conc_req_ff) & mask_w) == mask_w);
         end
         rsq_pkg::CMD_EXCL_TICK: begin
            excl_act_in = excl_tick_act;
            off_w       = excl_tick_off;
            on_w        = excl_tick_on;
         end
         rsq_pkg::CMD_CONC_TICK: begin
            conc_act_in = conc_tick_act;
            off_w       = conc_tick_off;
            on_w        = conc_tick_on;
         end
         default: begin
         end
      endcase
   end

   assign status_w = excl_act_in | conc_act_in;

   // Fit the relay masks back to the 16-bit result fields.
   generate
      for (genvar i = 0; i < FW; i++) begin : g_fit_out
         if (i < RELAY_COUNT) begin : g_live
            assign result.switched_off[i]  = off_w[i];
            assign result.switched_on[i]   = on_w[i];
            assign result.actual_status[i] = status_w[i];
         end else begin : g_dead
            assign result.switched_off[i]  = 1'b0;
            assign result.switched_on[i]   = 1'b0;
            assign result.actual_status[i] = 1'b0;
         end
      end
   endgenerate

   assign result.all_requested_on = answer;

   // Exclusive group mask register.
   always_ff @(posedge clock) begin
      if (reset) begin
         excl_mask_ff <= rsq_pkg::EXCLUSIVE_MASK_RESET;
      end else if (csr_wr_en) begin
         excl_mask_ff <= csr_wr_data;
      end
   end

   // Relay state advances once for each item that passes through.
   always_ff @(posedge clock) begin
      if (reset) begin
         excl_req_ff <= '0;
         conc_req_ff <= '0;
         excl_act_ff <= '0;
         conc_act_ff <= '0;
      end else if (step) begin
         excl_req_ff <= excl_req_in;
         conc_req_ff <= conc_req_in;
         excl_act_ff <= excl_act_in;
         conc_act_ff <= conc_act_in;
      end
   end

   // A relay is never switched off and on by the same tick.
   a_off_on_disjoint: assert property (@(posedge clock) disable iff (reset)
      step |-> ((off_w & on_w) == '0))
      else $error("relay switched off and on in one tick");

   // The exclusive group turns on at most one relay per tick.
   a_excl_one_on: assert property (@(posedge clock) disable iff (reset)
      (step && (item.command == rsq_pkg::CMD_EXCL_TICK)) |-> $onehot0(on_w))
      else $error("exclusive tick switched on more than one relay");

   // Actual masks only move on tick commands.
   a_act_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (step && (item.command != rsq_pkg::CMD_EXCL_TICK)
            && (item.command != rsq_pkg::CMD_CONC_TICK))
      |=> ($stable(excl_act_ff) && $stable(conc_act_ff)))
      else $error("actual relay state changed outside a tick");

endmodule

// ===== rtl/relay_switch_sequencer.sv =====
// ============================================================================
// Relay switch sequencer
// Tracks requested and actual on/off masks of an exclusive and a concurrent
// relay group and runs turn-on, turn-off, all-off, query and control tick commands.
// ============================================================================
// Pipeline: an accepted item sits in the input register, is decoded in one
// pass and its result is loaded into the result register and offered from
// there. Throughput: one item per cycle while the result side keeps ready
// high; a stalled result holds the input register.
// Reset: synchronous; clears all requests and actual states, sets the
// exclusive mask to relay 0 and empties both pipeline registers.
module relay_switch_sequencer #(
   parameter int unsigned RELAY_COUNT = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   rsq_req_if.sink                        req_if,
   rsq_rsp_if.source                      rsp_if,
   input  logic                           csr_wr_en,
   input  logic [rsq_pkg::MASK_WIDTH-1:0] csr_wr_data
);

   logic                 item_valid_ff;
   rsq_pkg::item_type    item_ff;
   logic                 rsp_valid_ff;
   rsq_pkg::result_type  rsp_ff;
   rsq_pkg::result_type  core_result;
   logic                 advance;
   logic                 accept;

   // The input register moves on when the result register is free or drains.
   assign advance     = item_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !item_valid_ff || advance;
   assign accept      = req_if.valid && req_if.ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         item_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.command    <= req_if.command;
         item_ff.relay_mask <= req_if.relay_mask;
      end
   end

   rsq_core #(.RELAY_COUNT(RELAY_COUNT)) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (item_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (core_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.switched_off     = rsp_ff.switched_off;
   assign rsp_if.switched_on      = rsp_ff.switched_on;
   assign rsp_if.all_requested_on = rsp_ff.all_requested_on;
   assign rsp_if.actual_status    = rsp_ff.actual_status;

   // An accepted item is held in the input register next cycle.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> item_valid_ff)
      else $error("accepted item did not reach the input register");

   // A held item that cannot advance is not dropped.
   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("stalled item lost from the input register");

   // Each advancing item shows up as a valid result next cycle.
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item produced no result");

endmodule
